// ===== src/coupled_tank_rk4_step_unit_macros.svh =====
// Assertion macros used by the checker file
`ifndef COUPLED_TANK_RK4_STEP_UNIT_MACROS_SVH
`define COUPLED_TANK_RK4_STEP_UNIT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define CTR_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication checked outside reset
`define CTR_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== src/ctr_pkg.sv =====
package ctr_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 64;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned IdxW = 3;

  // register indexes
  localparam logic [IdxW-1:0] RegPumpCoef1 = 3'd0;
  localparam logic [IdxW-1:0] RegPumpCoef2 = 3'd1;
  localparam logic [IdxW-1:0] RegOutletCoef1 = 3'd2;
  localparam logic [IdxW-1:0] RegOutletCoef2 = 3'd3;
  localparam logic [IdxW-1:0] RegDriveGain1 = 3'd4;
  localparam logic [IdxW-1:0] RegDriveGain2 = 3'd5;
  localparam logic [IdxW-1:0] RegDriveOffset1 = 3'd6;
  localparam logic [IdxW-1:0] RegDriveOffset2 = 3'd7;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sh0_7FFF_FFFF;
    lo = -66'sh0_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[DataW-1:0];
    end
  endfunction
endpackage

// ===== src/coupled_tank_rk4_step_unit.sv =====
// Sequence from an accepted request to a valid result: two serial drive products,
//   four slope rounds (square roots, four serial products, one combine), a serial
//   divide by six, then the FIN and OUT states to the output.
// Requests are taken only in the idle state, one at a time. A finished result waits
//   in the output register while the next request is taken and computed.
// Reset (rst, synchronous): levels, voltages, coefficients and offsets to zero, gains to 1.0.
module coupled_tank_rk4_step_unit
  import ctr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // tdata: update_pump_1, pump_cmd_1[32:1], update_pump_2, pump_cmd_2, pad
  input  logic [71:0]       s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // tdata: level_1, level_2
  output logic [63:0]       m_tdata,
  // tuser: pump_fault_1, pump_fault_2
  output logic [1:0]        m_tuser,
  input  logic              cfg_we,
  input  logic [IdxW-1:0]   cfg_index,
  input  logic [31:0]       cfg_data
);
  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001, S_DRV = 10'b0000000010, S_SQ = 10'b0000000100,
    S_MUL = 10'b0000001000, S_SLP = 10'b0000010000, S_FIN = 10'b0000100000,
    S_OUT = 10'b0001000000, S_DRVW = 10'b0010000000, S_MULW = 10'b0100000000,
    S_DIV = 10'b1000000000
  } state_t;

  state_t state;
  logic [30:0] pc1, pc2, oc1, oc2;
  logic signed [31:0] dg1, dg2, do1, do2;
  logic signed [31:0] lv1, lv2, pv1, pv2;
  logic signed [31:0] y1, y2, t1, t2;
  logic signed [65:0] sum1, sum2;
  logic [31:0] r1, r2;
  logic signed [65:0] p [4];
  logic [1:0] stg, pi;
  logic di;
  logic upd1, upd2;
  logic signed [31:0] cmd1, cmd2;
  logic [35:0] dq1, dq2;
  logic [2:0] rm1, rm2;
  logic neg1, neg2;
  logic [5:0] dcnt;

  // serial units
  logic ms, md, ss, sd1, sd2;
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic [31:0] sr1, sr2;

  ctr_mul u_mul (.clk, .rst, .start(ms), .op_a(ma), .op_b(mb), .done(md), .prod(mp));
  ctr_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sq1 (.clk, .rst, .start(ss), .level(t1),
    .done(sd1), .root(sr1));
  ctr_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sq2 (.clk, .rst, .start(ss), .level(t2),
    .done(sd2), .root(sr2));

  assign s_tready = (state == S_IDLE);

  // operand selection for the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    if (state == S_DRV || state == S_DRVW) begin
      ma = di ? 33'(dg2) : 33'(dg1);
      mb = di ? 33'(cmd2) : 33'(cmd1);
    end else begin
      case (pi)
        2'd0: begin ma = 33'({1'b0, oc1}); mb = 33'({1'b0, r1}); end
        2'd1: begin ma = 33'({1'b0, oc2}); mb = 33'({1'b0, r2}); end
        2'd2: begin ma = 33'({1'b0, pc1}); mb = 33'(pv1); end
        default: begin ma = 33'({1'b0, pc2}); mb = 33'(pv2); end
      endcase
    end
  end

  // slope combination, and one quotient bit per cycle of the divide by six
  logic signed [65:0] k1w, k2w;
  logic signed [31:0] k1, k2, h1, h2, n1, n2;
  logic signed [65:0] q1, q2;
  logic signed [65:0] fin1, fin2, mag1, mag2;
  logic [3:0] dr1, dr2;
  logic dge1, dge2;
  always_comb begin
    k1w = (p[2] - p[0]) >>> FRAC_BITS;
    k2w = (p[0] - p[1] + p[3]) >>> FRAC_BITS;
    k1 = sat32(k1w);
    k2 = sat32(k2w);
    h1 = (stg == 2'd2) ? k1 : (k1 >>> 1);
    h2 = (stg == 2'd2) ? k2 : (k2 >>> 1);
    n1 = sat32(66'(y1) + 66'(h1));
    n2 = sat32(66'(y2) + 66'(h2));
    fin1 = sum1 + 66'(k1);
    fin2 = sum2 + 66'(k2);
    mag1 = fin1[65] ? -fin1 : fin1;
    mag2 = fin2[65] ? -fin2 : fin2;
    dr1 = {rm1, dq1[35]};
    dr2 = {rm2, dq2[35]};
    dge1 = (dr1 >= 4'd6);
    dge2 = (dr2 >= 4'd6);
    q1 = 66'(dq1);
    if (neg1) q1 = -q1;
    q2 = 66'(dq2);
    if (neg2) q2 = -q2;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pc1 <= '0; pc2 <= '0; oc1 <= '0; oc2 <= '0;
      dg1 <= 32'sd1 <<< FRAC_BITS; dg2 <= 32'sd1 <<< FRAC_BITS;
      do1 <= '0; do2 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegPumpCoef1: pc1 <= cfg_data[30:0];
        RegPumpCoef2: pc2 <= cfg_data[30:0];
        RegOutletCoef1: oc1 <= cfg_data[30:0];
        RegOutletCoef2: oc2 <= cfg_data[30:0];
        RegDriveGain1: dg1 <= cfg_data;
        RegDriveGain2: dg2 <= cfg_data;
        RegDriveOffset1: do1 <= cfg_data;
        RegDriveOffset2: do2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // step sequencer
  always_ff @(posedge clk) begin
    ms <= 1'b0;
    ss <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      lv1 <= '0; lv2 <= '0; pv1 <= '0; pv2 <= '0;
      stg <= '0; pi <= '0; di <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid && s_tready) begin
          upd1 <= s_tdata[0];
          cmd1 <= s_tdata[32:1];
          upd2 <= s_tdata[33];
          cmd2 <= s_tdata[65:34];
          di <= 1'b0;
          ms <= 1'b1;
          state <= S_DRVW;
        end
        S_DRVW: state <= S_DRV;
        S_DRV: if (md) begin
          if (!di) begin
            if (upd1) pv1 <= sat32((mp >>> FRAC_BITS) + 66'(do1));
            di <= 1'b1;
            ms <= 1'b1;
            state <= S_DRVW;
          end else begin
            if (upd2) pv2 <= sat32((mp >>> FRAC_BITS) + 66'(do2));
            y1 <= lv1[31] ? '0 : lv1;
            y2 <= lv2[31] ? '0 : lv2;
            t1 <= lv1[31] ? '0 : lv1;
            t2 <= lv2[31] ? '0 : lv2;
            sum1 <= '0; sum2 <= '0; stg <= '0;
            ss <= 1'b1;
            state <= S_SQ;
          end
        end
        S_SQ: if (sd1 && sd2) begin
          r1 <= sr1; r2 <= sr2;
          pi <= '0;
          ms <= 1'b1;
          state <= S_MULW;
        end
        S_MULW: state <= S_MUL;
        S_MUL: if (md) begin
          p[pi] <= mp;
          pi <= pi + 2'd1;
          if (pi == 2'd3) state <= S_SLP;
          else begin
            ms <= 1'b1;
            state <= S_MULW;
          end
        end
        S_SLP: begin
          if (stg == 2'd0 || stg == 2'd3) begin
            sum1 <= sum1 + 66'(k1); sum2 <= sum2 + 66'(k2);
          end else begin
            sum1 <= sum1 + (66'(k1) <<< 1); sum2 <= sum2 + (66'(k2) <<< 1);
          end
          if (stg == 2'd3) begin
            dq1 <= mag1[35:0]; dq2 <= mag2[35:0];
            neg1 <= fin1[65]; neg2 <= fin2[65];
            rm1 <= '0; rm2 <= '0;
            dcnt <= '0;
            state <= S_DIV;
          end else begin
            t1 <= n1; t2 <= n2;
            stg <= stg + 2'd1;
            ss <= 1'b1;
            state <= S_SQ;
          end
        end
        // shift the weighted sum magnitudes through, remainder stays below six
        S_DIV: begin
          rm1 <= dge1 ? 3'(dr1 - 4'd6) : dr1[2:0];
          rm2 <= dge2 ? 3'(dr2 - 4'd6) : dr2[2:0];
          dq1 <= {dq1[34:0], dge1};
          dq2 <= {dq2[34:0], dge2};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd35) state <= S_FIN;
        end
        S_FIN: begin
          lv1 <= sat32(66'(y1) + q1);
          lv2 <= sat32(66'(y2) + q2);
          state <= S_OUT;
        end
        S_OUT: if (!m_tvalid) begin
          m_tdata <= {lv2, lv1};
          m_tuser[0] <= (pv1 > (32'sd15 <<< FRAC_BITS)) || (pv1 < -(32'sd15 <<< FRAC_BITS));
          m_tuser[1] <= (pv2 > (32'sd15 <<< FRAC_BITS)) || (pv2 < -(32'sd15 <<< FRAC_BITS));
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/ctr_mul.sv =====
// Serial signed multiplier: one multiplier bit per cycle, 33 x 33 -> 66 bits
module ctr_mul
  import ctr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [32:0]  op_a,
  input  logic signed [32:0]  op_b,
  output logic                done,
  output logic signed [65:0]  prod
);
  logic signed [65:0] acc;
  logic [32:0] mb;
  logic signed [65:0] ma;
  logic [5:0] cnt;
  logic busy;

  assign prod = acc;

  // shift and add, last bit subtracts (two's complement sign weight)
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      acc <= '0;
      ma <= 66'(op_a);
      mb <= op_b;
    end else if (busy) begin
      if (mb[0]) begin
        if (cnt == 6'd32) acc <= acc - ma;
        else acc <= acc + ma;
      end
      ma <= ma <<< 1;
      mb <= mb >> 1;
      cnt <= cnt + 6'd1;
      if (cnt == 6'd32) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== src/ctr_sqrt.sv =====
// Serial square root: two radicand bits per cycle over a 64-bit radicand
module ctr_sqrt
  import ctr_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] level,
  output logic               done,
  output logic [31:0]        root
);
  localparam int unsigned RadW = 64;
  logic [RadW-1:0] rad;
  logic [RadW-1:0] rem;
  logic [31:0] res;
  logic [5:0] cnt;
  logic busy;
  logic [RadW-1:0] trial;
  logic [RadW-1:0] rem_sh;
  logic [RadW-1:0] cand;

  assign root = res;
  assign rem_sh = {rem[RadW-3:0], rad[RadW-1:RadW-2]};
  assign cand = {{(RadW-34){1'b0}}, res, 2'b01};
  assign trial = rem_sh - cand;

  // restoring digit recurrence, level below zero counts as zero
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= '0;
      rem <= '0;
      res <= '0;
      rad <= level[31] ? '0 : (RadW'(unsigned'(level)) << FRAC_BITS);
    end else if (busy) begin
      rad <= rad << 2;
      if (rem_sh >= cand) begin
        rem <= trial;
        res <= {res[30:0], 1'b1};
      end else begin
        rem <= rem_sh;
        res <= {res[30:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

// ===== src/ctr_checker.sv =====
`include "coupled_tank_rk4_step_unit_macros.svh"
module ctr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata
);
  // an offered result carries known data
  `CTR_ASSERT_IMP(a_out_known, clk, rst, m_tvalid, !$isunknown(m_tdata))
  // accepted input stops further acceptance next cycle
  `CTR_ASSERT_NXT(a_busy_after_in, clk, rst, s_tvalid && s_tready, !s_tready)
  // stalled result holds
  `CTR_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind coupled_tank_rk4_step_unit ctr_checker u_ctr_checker (.*);

// ===== test/testbench.sv =====
module testbench;
  import ctr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 16;
  localparam int FaultLim = 15 << FracBits;
  localparam int StepCycles = 700;
  localparam longint CycleLimit = 12_000_000;

  typedef struct {
    int  level_1;
    int  level_2;
    bit  fault_1;
    bit  fault_2;
  } tank_sample_t;

  // Predicts the plant step by step and holds the levels still to come back
  class tank_board;
    bit [30:0] pump_k1, pump_k2, outlet_k1, outlet_k2;
    int gain1, gain2, offset1, offset2;
    int level1, level2, volt1, volt2;
    tank_sample_t pending[$];
    int errors;
    int checked;
    int faults_seen;

    function new();
      pump_k1 = 0; pump_k2 = 0; outlet_k1 = 0; outlet_k2 = 0;
      gain1 = 1 << FracBits; gain2 = 1 << FracBits;
      offset1 = 0; offset2 = 0;
      level1 = 0; level2 = 0; volt1 = 0; volt2 = 0;
      errors = 0; checked = 0; faults_seen = 0;
    endfunction

    function int clamp(longint v);
      if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return int'(v);
    endfunction

    // floor(sqrt(x * 2^FracBits)), negative or zero level gives zero
    function longint root_q(int x);
      longint unsigned n, res, b;
      if (x <= 0) return 0;
      n = longint'(x) << FracBits;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return longint'(res);
    endfunction

    function void slope_pair(int h1, int h2, output int k1, output int k2);
      longint out1, out2, in1, in2;
      out1 = longint'({1'b0, outlet_k1}) * root_q(h1);
      out2 = longint'({1'b0, outlet_k2}) * root_q(h2);
      in1 = longint'({1'b0, pump_k1}) * longint'(volt1);
      in2 = longint'({1'b0, pump_k2}) * longint'(volt2);
      k1 = clamp((in1 - out1) >>> FracBits);
      k2 = clamp((out1 - out2 + in2) >>> FracBits);
    endfunction

    function void set_reg(logic [IdxW-1:0] idx, logic [31:0] val);
      case (idx)
        RegPumpCoef1:    pump_k1 = val[30:0];
        RegPumpCoef2:    pump_k2 = val[30:0];
        RegOutletCoef1:  outlet_k1 = val[30:0];
        RegOutletCoef2:  outlet_k2 = val[30:0];
        RegDriveGain1:   gain1 = val;
        RegDriveGain2:   gain2 = val;
        RegDriveOffset1: offset1 = val;
        RegDriveOffset2: offset2 = val;
        default: ;
      endcase
    endfunction

    // Advance the plant by one accepted request
    function void note_request(bit upd1, int cmd1, bit upd2, int cmd2);
      int y1, y2, a1, a2, b1, b2, c1, c2, d1, d2, t1, t2;
      longint s1, s2;
      tank_sample_t exp_s;
      if (upd1) volt1 = clamp(((longint'(gain1) * longint'(cmd1)) >>> FracBits) + offset1);
      if (upd2) volt2 = clamp(((longint'(gain2) * longint'(cmd2)) >>> FracBits) + offset2);
      y1 = level1 < 0 ? 0 : level1;
      y2 = level2 < 0 ? 0 : level2;
      slope_pair(y1, y2, a1, a2);
      t1 = clamp(longint'(y1) + (longint'(a1) >>> 1));
      t2 = clamp(longint'(y2) + (longint'(a2) >>> 1));
      slope_pair(t1, t2, b1, b2);
      t1 = clamp(longint'(y1) + (longint'(b1) >>> 1));
      t2 = clamp(longint'(y2) + (longint'(b2) >>> 1));
      slope_pair(t1, t2, c1, c2);
      t1 = clamp(longint'(y1) + c1);
      t2 = clamp(longint'(y2) + c2);
      slope_pair(t1, t2, d1, d2);
      s1 = longint'(a1) + 2 * longint'(b1) + 2 * longint'(c1) + longint'(d1);
      s2 = longint'(a2) + 2 * longint'(b2) + 2 * longint'(c2) + longint'(d2);
      level1 = clamp(longint'(y1) + s1 / 6);
      level2 = clamp(longint'(y2) + s2 / 6);
      exp_s.level_1 = level1;
      exp_s.level_2 = level2;
      exp_s.fault_1 = (volt1 > FaultLim) || (volt1 < -FaultLim);
      exp_s.fault_2 = (volt2 > FaultLim) || (volt2 < -FaultLim);
      pending.push_back(exp_s);
    endfunction

    function void check_result(int l1, int l2, bit f1, bit f2);
      tank_sample_t e;
      if (pending.size() == 0) begin
        $error("unexpected result: level_1 %0d level_2 %0d", l1, l2);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (f1 || f2) faults_seen++;
      if (l1 != e.level_1) begin
        $error("level_1: expected %0d, got %0d", e.level_1, l1); errors++;
      end
      if (l2 != e.level_2) begin
        $error("level_2: expected %0d, got %0d", e.level_2, l2); errors++;
      end
      if (f1 != e.fault_1) begin
        $error("pump_fault_1: expected %0d, got %0d", e.fault_1, f1); errors++;
      end
      if (f2 != e.fault_2) begin
        $error("pump_fault_2: expected %0d, got %0d", e.fault_2, f2); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [71:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_we = 1'b0;
  logic [IdxW-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // 0 none, 1 sender idles, 2 receiver stalls, 3 both lightly
  int idle_mode = 0;
  int hold_left = 0;
  longint cycles = 0;
  tank_board board = new();

  coupled_tank_rk4_step_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Observe both handshakes and guard the run length
  always @(posedge clk) begin
    cycles++;
    if (!rst) begin
      if (s_tvalid && s_tready)
        board.note_request(s_tdata[0], s_tdata[32:1], s_tdata[33], s_tdata[65:34]);
      if (m_tvalid && m_tready)
        board.check_result(m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]);
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: stall at random, or hold off for a long stretch when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      case (idle_mode)
        2: m_tready <= ($urandom_range(0, 99) >= 47);
        3: m_tready <= ($urandom_range(0, 99) >= 10);
        default: m_tready <= 1'b1;
      endcase
    end
  end

  task automatic write_reg(logic [IdxW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    board.set_reg(idx, val);
  endtask

  task automatic load_setting(int pc1, int pc2, int oc1, int oc2,
                              int g1, int g2, int o1, int o2);
    write_reg(RegPumpCoef1, pc1);
    write_reg(RegPumpCoef2, pc2);
    write_reg(RegOutletCoef1, oc1);
    write_reg(RegOutletCoef2, oc2);
    write_reg(RegDriveGain1, g1);
    write_reg(RegDriveGain2, g2);
    write_reg(RegDriveOffset1, o1);
    write_reg(RegDriveOffset2, o2);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one request and hold it until taken
  task automatic send_request(bit upd1, int cmd1, bit upd2, int cmd2);
    @(negedge clk);
    while ((idle_mode == 1 && $urandom_range(0, 99) < 47) ||
           (idle_mode == 3 && $urandom_range(0, 99) < 10)) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {6'b0, cmd2, upd2, cmd1, upd1};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic int pick_cmd();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: return FaultLim;
          1: return FaultLim + 1;
          2: return -FaultLim;
          3: return -FaultLim - 1;
          4: return 32'sh7FFF_FFFF;
          default: return 32'sh8000_0000;
        endcase
      end
      default: return int'($urandom_range(0, 40 << FracBits)) - (20 << FracBits);
    endcase
  endfunction

  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (StepCycles) @(posedge clk);
  endtask

  task automatic random_phase(int mode, int count);
    idle_mode = mode;
    repeat (count)
      send_request($urandom_range(0, 1), pick_cmd(), $urandom_range(0, 1), pick_cmd());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset coefficients, command extremes and fault thresholds
    send_request(1, 0, 1, 0);
    send_request(1, FaultLim, 1, -FaultLim);
    send_request(1, FaultLim + 1, 1, -FaultLim - 1);
    send_request(0, 0, 0, 0);
    send_request(1, 32'sh7FFF_FFFF, 1, 32'sh8000_0000);
    send_request(1, 32'sh8000_0000, 0, 32'sh7FFF_FFFF);
    send_request(0, 32'sh7FFF_FFFF, 1, 0);
    send_request(1, -1, 1, 1);
    drain();

    // Nominal plant: tanks fill, drain, and go through saturation
    load_setting(1000, 800, 300, 250, 3 << FracBits, 2 << FracBits, 1 << 14, -(1 << 14));
    send_request(1, 5 << FracBits, 1, 4 << FracBits);
    send_request(0, 0, 0, 0);
    send_request(1, -(8 << FracBits), 1, -(8 << FracBits));
    send_request(0, 0, 0, 0);
    send_request(1, 0, 1, 0);
    drain();
    random_phase(0, 250);

    // Long receiver hold-off so the block backs up into its input
    @(posedge clk);
    hold_left = 4000;
    random_phase(0, 30);

    // Extremes: largest coefficients and gains drive saturation everywhere
    load_setting(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000);
    send_request(1, 1, 1, 1);
    send_request(1, -1, 1, -1);
    send_request(0, 0, 0, 0);
    drain();
    random_phase(1, 250);

    // Strong inflow, no outlet: levels run to the top and go negative
    load_setting(40000, 30000, 0, 0, 1 << FracBits, -(1 << FracBits), 0, 0);
    random_phase(2, 250);

    // Zero coefficients and gains, offsets beyond the fault limit: levels held, only the faults move
    load_setting(0, 0, 0, 0, 0, 0, 20 << FracBits, -(20 << FracBits));
    random_phase(3, 150);

    // Random settings with small to moderate values, but for a full-range second drive offset
    for (int p = 0; p < 4; p++) begin
      load_setting($urandom_range(0, 1 << 16), $urandom_range(0, 1 << 16),
                   $urandom_range(0, 1 << 14), $urandom_range(0, 1 << 14),
                   int'($urandom_range(0, 8 << FracBits)) - (4 << FracBits),
                   int'($urandom_range(0, 8 << FracBits)) - (4 << FracBits),
                   int'($urandom_range(0, 4 << FracBits)) - (2 << FracBits),
                   $urandom);
      random_phase(p, 150);
    end

    $display("checked %0d plant steps across 8 register settings and 4 idling phases",
             board.checked);
    $display("%0d results carried a pump fault", board.faults_seen);
    if (board.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
